// File: hdl/awme_pkg.sv
// Package: shared types, codes and constants of the word-machine executor.
package awme_pkg;

    // Sizes
    localparam int MEM_WORDS   = 100;
    localparam int BLOCK_WORDS = 10;
    localparam int ADDR_W      = 7;
    localparam int WORD_W      = 32;
    localparam int FW_W        = 4;

    // Item commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_DATA    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_HALT    = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_BAD_OP  = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;
    localparam logic [2:0] ST_REFUSED = 3'd6;
    localparam logic [2:0] ST_NO_DATA = 3'd7;

    // ASCII codes and marker words
    localparam logic [7:0]  CH_G     = 8'h47;
    localparam logic [7:0]  CH_D     = 8'h44;
    localparam logic [7:0]  CH_P     = 8'h50;
    localparam logic [7:0]  CH_H     = 8'h48;
    localparam logic [7:0]  CH_L     = 8'h4C;
    localparam logic [7:0]  CH_S     = 8'h53;
    localparam logic [7:0]  CH_C     = 8'h43;
    localparam logic [7:0]  CH_R     = 8'h52;
    localparam logic [7:0]  CH_B     = 8'h42;
    localparam logic [7:0]  CH_T     = 8'h54;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [WORD_W-1:0] SPACES   = 32'h2020_2020;
    localparam logic [WORD_W-1:0] END_MARK = 32'h2445_4E44;

    // Machine run mode
    typedef enum logic [1:0] {
        MODE_RUN,
        MODE_WAIT,
        MODE_HALT
    } t_mode;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_X_DEC,
        S_X_MEM,
        S_P_RD,
        S_P_EMIT,
        S_D_BYTE,
        S_D_WR,
        S_EMIT
    } t_state;

    // Word store access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: hdl/awme_if.sv
// Interfaces: input item channel and result channel.
interface awme_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [awme_pkg::ADDR_W-1:0]   address;
    logic [awme_pkg::WORD_W-1:0]   word_in;
    logic [2:0]                    byte_count;
    logic                          data_last;

    modport source (output valid, cmd, address, word_in, byte_count, data_last,
                    input ready);
    modport sink   (input valid, cmd, address, word_in, byte_count, data_last,
                    output ready);
endinterface

interface awme_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [awme_pkg::WORD_W-1:0]   word_out;
    logic                          last;
    logic [2:0]                    status;
    logic [awme_pkg::ADDR_W-1:0]   counter;

    modport source (output valid, kind, word_out, last, status, counter,
                    input ready);
    modport sink   (input valid, kind, word_out, last, status, counter,
                    output ready);
endinterface

// File: hdl/awme_mem.sv
// Word store: synchronous memory with one write port, one registered read port and per-entry valid bits.
module awme_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  awme_pkg::t_mem_req          i_req,
    output logic [awme_pkg::WORD_W-1:0] o_rdata
);

    logic [awme_pkg::WORD_W-1:0] r_mem [awme_pkg::MEM_WORDS];
    logic [awme_pkg::MEM_WORDS-1:0] r_vld;
    logic [awme_pkg::WORD_W-1:0] r_rdata;
    logic                        r_rvld;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    // Valid bits: an unwritten entry reads as spaces
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : awme_pkg::SPACES;

endmodule

// File: hdl/awme_ctrl.sv
// Sequencer: item decode, instruction execute, block fill and print, result register.
module awme_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    awme_in_if.sink                     i_in,
    awme_out_if.source                  o_res,
    output awme_pkg::t_mem_req          o_mem,
    input  logic [awme_pkg::WORD_W-1:0] i_rdata
);

    // Control state
    awme_pkg::t_state r_state, n_state;
    awme_pkg::t_mode  r_mode, n_mode;
    logic [6:0] r_ic, n_ic;
    logic       r_tog, n_tog;
    logic [3:0] r_fill_word, n_fill_word;
    logic [1:0] r_fill_byte, n_fill_byte;
    logic [6:0] r_fill_base, n_fill_base;
    logic [2:0] r_idx, n_idx;
    logic       r_drop, n_drop;
    logic [3:0] r_k, n_k;
    logic       r_ov, n_ov;

    // Payload state
    logic [31:0] r_gr, n_gr;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last_in, n_last_in;
    logic        r_is_lr, n_is_lr;
    logic [2:0]  r_stat, n_stat;
    logic [6:0]  r_ptr, n_ptr;
    logic        r_okind, n_okind;
    logic [31:0] r_oword, n_oword;
    logic        r_olast, n_olast;
    logic [2:0]  r_ostat, n_ostat;
    logic [6:0]  r_octr, n_octr;

    // Instruction fields from the read word
    logic [7:0] b0, b1, b2, b3;
    logic       op_ok;
    logic [6:0] base7, op7;
    logic       slot_free, in_fire;
    logic [7:0] data_byte;
    logic [31:0] merged;

    assign b0 = i_rdata[31:24];
    assign b1 = i_rdata[23:16];
    assign b2 = i_rdata[15:8];
    assign b3 = i_rdata[7:0];
    assign op_ok = (b2 >= awme_pkg::CH_ZERO) && (b2 <= awme_pkg::CH_NINE) &&
                   (b3 >= awme_pkg::CH_ZERO) && (b3 <= awme_pkg::CH_NINE);
    assign base7 = {b2[3:0], 3'b000} + {2'b00, b2[3:0], 1'b0};
    assign op7   = base7 + {3'b000, b3[3:0]};

    assign slot_free = !r_ov || o_res.ready;
    assign in_fire   = i_in.valid && (r_state == awme_pkg::S_IDLE);

    // Byte of the data word and merge into the target word
    always_comb begin
        case (r_idx[1:0])
            2'd0:    data_byte = r_word[31:24];
            2'd1:    data_byte = r_word[23:16];
            2'd2:    data_byte = r_word[15:8];
            default: data_byte = r_word[7:0];
        endcase
        case (r_fill_byte)
            2'd0:    merged = {data_byte, i_rdata[23:0]};
            2'd1:    merged = {i_rdata[31:24], data_byte, i_rdata[15:0]};
            2'd2:    merged = {i_rdata[31:16], data_byte, i_rdata[7:0]};
            default: merged = {i_rdata[31:8], data_byte};
        endcase
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ic        = r_ic;
        n_tog       = r_tog;
        n_fill_word = r_fill_word;
        n_fill_byte = r_fill_byte;
        n_fill_base = r_fill_base;
        n_idx       = r_idx;
        n_drop      = r_drop;
        n_k         = r_k;
        n_gr        = r_gr;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_last_in   = r_last_in;
        n_is_lr     = r_is_lr;
        n_stat      = r_stat;
        n_ptr       = r_ptr;
        n_ov        = r_ov && !o_res.ready;
        n_okind     = r_okind;
        n_oword     = r_oword;
        n_olast     = r_olast;
        n_ostat     = r_ostat;
        n_octr      = r_octr;
        o_mem       = '0;
        i_in.ready  = (r_state == awme_pkg::S_IDLE);

        case (r_state)
            awme_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state   = awme_pkg::S_EMIT;
                    n_word    = i_in.word_in;
                    n_last_in = i_in.data_last;
                    n_cnt     = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
                    case (i_in.cmd)
                        awme_pkg::CMD_LOAD: begin
                            if (i_in.address < 7'(awme_pkg::MEM_WORDS)) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = i_in.address;
                                o_mem.wdata = i_in.word_in;
                                n_stat      = awme_pkg::ST_OK;
                            end else begin
                                n_stat = awme_pkg::ST_REFUSED;
                            end
                        end
                        awme_pkg::CMD_EXEC: begin
                            if (r_mode == awme_pkg::MODE_WAIT) begin
                                n_stat = awme_pkg::ST_REFUSED;
                            end else if (r_mode == awme_pkg::MODE_HALT) begin
                                n_stat = awme_pkg::ST_HALT;
                            end else if (r_ic >= 7'(awme_pkg::MEM_WORDS)) begin
                                n_stat = awme_pkg::ST_END;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_ic;
                                n_state     = awme_pkg::S_X_DEC;
                            end
                        end
                        awme_pkg::CMD_DATA: begin
                            if (r_mode != awme_pkg::MODE_WAIT) begin
                                n_stat = awme_pkg::ST_REFUSED;
                            end else if (r_fill_word == '0 && r_fill_byte == '0 &&
                                         i_in.data_last && i_in.byte_count == 3'd4 &&
                                         i_in.word_in == awme_pkg::END_MARK) begin
                                n_mode = awme_pkg::MODE_HALT;
                                n_stat = awme_pkg::ST_NO_DATA;
                            end else begin
                                n_idx   = '0;
                                n_drop  = 1'b0;
                                n_state = awme_pkg::S_D_BYTE;
                            end
                        end
                        awme_pkg::CMD_RESTART: begin
                            n_ic        = '0;
                            n_mode      = awme_pkg::MODE_RUN;
                            n_fill_word = '0;
                            n_fill_byte = '0;
                            n_fill_base = '0;
                            n_stat      = awme_pkg::ST_OK;
                        end
                        default: n_stat = awme_pkg::ST_REFUSED;
                    endcase
                end
            end

            // Decode the instruction word at the counter
            awme_pkg::S_X_DEC: begin
                n_state = awme_pkg::S_EMIT;
                n_stat  = awme_pkg::ST_OK;
                if (b1 == awme_pkg::CH_D && (b0 == awme_pkg::CH_G || b0 == awme_pkg::CH_P)) begin
                    if (!op_ok) begin
                        n_stat = awme_pkg::ST_BAD_OP;
                    end else if (b0 == awme_pkg::CH_G) begin
                        n_fill_base = base7;
                        n_fill_word = '0;
                        n_fill_byte = '0;
                        n_mode      = awme_pkg::MODE_WAIT;
                        n_stat      = awme_pkg::ST_WAIT;
                    end else begin
                        n_ic    = r_ic + 7'd1;
                        n_ptr   = base7;
                        n_k     = '0;
                        n_state = awme_pkg::S_P_RD;
                    end
                end else if (b0 == awme_pkg::CH_H) begin
                    n_mode = awme_pkg::MODE_HALT;
                    n_stat = awme_pkg::ST_HALT;
                end else if (b1 == awme_pkg::CH_R && (b0 == awme_pkg::CH_L ||
                             b0 == awme_pkg::CH_S || b0 == awme_pkg::CH_C)) begin
                    if (!op_ok) begin
                        n_stat = awme_pkg::ST_BAD_OP;
                    end else if (b0 == awme_pkg::CH_S) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = op7;
                        o_mem.wdata = r_gr;
                        n_ic        = r_ic + 7'd1;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = op7;
                        n_is_lr     = (b0 == awme_pkg::CH_L);
                        n_state     = awme_pkg::S_X_MEM;
                    end
                end else if (b0 == awme_pkg::CH_B && b1 == awme_pkg::CH_T) begin
                    if (!op_ok) begin
                        n_stat = awme_pkg::ST_BAD_OP;
                    end else begin
                        n_ic = r_tog ? op7 : r_ic + 7'd1;
                    end
                end else begin
                    n_ic = r_ic + 7'd1;
                end
            end

            // Operand word for LR or CR
            awme_pkg::S_X_MEM: begin
                if (r_is_lr) begin
                    n_gr = i_rdata;
                end else begin
                    n_tog = (r_gr == i_rdata);
                end
                n_ic    = r_ic + 7'd1;
                n_stat  = awme_pkg::ST_OK;
                n_state = awme_pkg::S_EMIT;
            end

            // Print: read one block word, then emit it
            awme_pkg::S_P_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_ptr;
                n_state     = awme_pkg::S_P_EMIT;
            end

            awme_pkg::S_P_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = 1'b1;
                    n_oword = i_rdata;
                    n_olast = (r_k == 4'(awme_pkg::BLOCK_WORDS - 1));
                    n_ostat = awme_pkg::ST_OK;
                    n_octr  = r_ic;
                    n_ptr   = r_ptr + 7'd1;
                    n_k     = r_k + 4'd1;
                    n_state = (r_k == 4'(awme_pkg::BLOCK_WORDS - 1)) ?
                              awme_pkg::S_IDLE : awme_pkg::S_P_RD;
                end
            end

            // Fill: one byte per read-modify-write
            awme_pkg::S_D_BYTE: begin
                if (r_idx == r_cnt) begin
                    if (r_last_in) begin
                        n_mode = awme_pkg::MODE_RUN;
                        n_ic   = r_ic + 7'd1;
                        n_stat = awme_pkg::ST_OK;
                    end else begin
                        n_stat = awme_pkg::ST_WAIT;
                    end
                    if (r_drop) begin
                        n_stat = awme_pkg::ST_OVERRUN;
                    end
                    n_state = awme_pkg::S_EMIT;
                end else if (r_fill_word >= 4'(awme_pkg::BLOCK_WORDS)) begin
                    n_drop = 1'b1;
                    n_idx  = r_idx + 3'd1;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_fill_base + {3'b000, r_fill_word};
                    n_state     = awme_pkg::S_D_WR;
                end
            end

            awme_pkg::S_D_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_fill_base + {3'b000, r_fill_word};
                o_mem.wdata = merged;
                n_fill_byte = r_fill_byte + 2'd1;
                if (r_fill_byte == 2'd3) begin
                    n_fill_word = r_fill_word + 4'd1;
                end
                n_idx   = r_idx + 3'd1;
                n_state = awme_pkg::S_D_BYTE;
            end

            // Status-only result beat
            awme_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = 1'b0;
                    n_oword = '0;
                    n_olast = 1'b1;
                    n_ostat = r_stat;
                    n_octr  = r_ic;
                    n_state = awme_pkg::S_IDLE;
                end
            end

            default: n_state = awme_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= awme_pkg::S_IDLE;
            r_mode      <= awme_pkg::MODE_RUN;
            r_ic        <= '0;
            r_tog       <= 1'b0;
            r_fill_word <= '0;
            r_fill_byte <= '0;
            r_fill_base <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_k         <= '0;
            r_ov        <= 1'b0;
            r_gr        <= awme_pkg::SPACES;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_ic        <= n_ic;
            r_tog       <= n_tog;
            r_fill_word <= n_fill_word;
            r_fill_byte <= n_fill_byte;
            r_fill_base <= n_fill_base;
            r_idx       <= n_idx;
            r_drop      <= n_drop;
            r_k         <= n_k;
            r_ov        <= n_ov;
            r_gr        <= n_gr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_cnt     <= n_cnt;
        r_last_in <= n_last_in;
        r_is_lr   <= n_is_lr;
        r_stat    <= n_stat;
        r_ptr     <= n_ptr;
        r_okind   <= n_okind;
        r_oword   <= n_oword;
        r_olast   <= n_olast;
        r_ostat   <= n_ostat;
        r_octr    <= n_octr;
    end

    assign o_res.valid    = r_ov;
    assign o_res.kind     = r_okind;
    assign o_res.word_out = r_oword;
    assign o_res.last     = r_olast;
    assign o_res.status   = r_ostat;
    assign o_res.counter  = r_octr;

endmodule

// File: hdl/ascii_word_machine_executor_top.sv
// Path, input beat to result beat: load, restart and refusals go straight to the status beat;
// an executed step first reads its instruction word, LR and CR then read a second word, as PD does for its first word.
// PD then reads and emits its other nine words, one store read per word.
// A data item: a read and a write back per stored byte, no store access for a dropped byte, then a status beat.
// One item at a time; the next is taken once its results are registered for output.
// Reset (synchronous, active low) clears control state and the store's valid bits at once.
module ascii_word_machine_executor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    awme_in_if.sink    i_in,
    awme_out_if.source o_res
);

    awme_pkg::t_mem_req          mem_req;
    logic [awme_pkg::WORD_W-1:0] mem_rdata;

    // Sequencer
    awme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    // Program and data store
    awme_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// File: hdl/awme_chk.sv
// Checker: result-channel properties of the executor, bound to the top level.
module awme_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_kind,
    input logic [awme_pkg::WORD_W-1:0] i_out_word,
    input logic                        i_out_last,
    input logic [2:0]                  i_out_status,
    input logic [awme_pkg::ADDR_W-1:0] i_out_counter
);

    // No beat offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word) &&
        $stable(i_out_status) && $stable(i_out_last) && $stable(i_out_kind))
        else $error("stalled result beat changed");

    // A status-only beat ends its item and carries no word
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_kind |-> i_out_last && i_out_word == '0)
        else $error("bad status-only beat");

    // Printed words are always reported ok
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind |-> i_out_status == awme_pkg::ST_OK)
        else $error("printed word with error status");

    // Counter never passes the end of memory
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_counter <= 7'(awme_pkg::MEM_WORDS))
        else $error("counter out of range");

endmodule

bind ascii_word_machine_executor_top awme_chk u_awme_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_kind    (o_res.kind),
    .i_out_word    (o_res.word_out),
    .i_out_last    (o_res.last),
    .i_out_status  (o_res.status),
    .i_out_counter (o_res.counter)
);
